// ===== hw/rtl/isrr_pkg.sv =====
// Shared types, constants and microcode for the in-order slice release buffer.
// Used by isrr_seq, isrr_dp and the top level; depends on nothing.
`default_nettype none

package isrr_pkg;

  localparam int RING_SLOTS  = 4;
  localparam int MAX_SLICES  = 8;
  localparam int SLOT_W      = $clog2(RING_SLOTS);
  localparam int SIDX_W      = $clog2(MAX_SLICES);
  localparam int REL_W       = $clog2(MAX_SLICES + 1);
  localparam int CNT_W       = 4;
  localparam int STORE_DEPTH = RING_SLOTS * MAX_SLICES;
  localparam int FRAME_W     = 32;
  localparam int WORD_W      = 32;
  localparam int BYTES_W     = 24;
  localparam int HDR_W       = 16;
  localparam int SPF_W       = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int UPC_W       = 5;

  localparam logic [CNT_W-1:0] DONE_SAT = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_PMODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPF   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR   = 2'd2;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_id;
    logic [2:0]         slice_index;
    logic               slice_failed;
    logic [BYTES_W-1:0] slice_bytes;
  } isrr_in_t;

  typedef struct packed {
    logic [FRAME_W-1:0] out_frame;
    logic [WORD_W-1:0]  byte_offset;
    logic [WORD_W-1:0]  byte_length;
    logic               is_header;
    logic               last_in_frame;
    logic               frame_failed;
    logic               status;
    logic               last_of_run;
  } isrr_out_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_UPDATE,
    OP_EMIT_DROP,
    OP_RD_REL,
    OP_EMIT_HDR,
    OP_EMIT_SLICE,
    OP_SUM_INIT,
    OP_RD_IDX,
    OP_SUM_ADD,
    OP_EMIT_WHOLE,
    OP_FREE,
    OP_FLUSH
  } isrr_op_e;

  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_IN,
    C_BUSY,
    C_HEAD_FREE,
    C_NOT_PMODE,
    C_PMODE,
    C_REL_STOP,
    C_REL_NZ,
    C_DONE_LT,
    C_IDX_END
  } isrr_cond_e;

  // microprogram step addresses
  localparam logic [UPC_W-1:0] S_IDLE    = 5'd0;
  localparam logic [UPC_W-1:0] S_CHECK   = 5'd1;
  localparam logic [UPC_W-1:0] S_UPDATE  = 5'd2;
  localparam logic [UPC_W-1:0] S_DROP    = 5'd3;
  localparam logic [UPC_W-1:0] S_WALK    = 5'd4;
  localparam logic [UPC_W-1:0] S_WMODE   = 5'd5;
  localparam logic [UPC_W-1:0] S_LOOP    = 5'd6;
  localparam logic [UPC_W-1:0] S_LTEST   = 5'd7;
  localparam logic [UPC_W-1:0] S_LHDR    = 5'd8;
  localparam logic [UPC_W-1:0] S_LSLICE  = 5'd9;
  localparam logic [UPC_W-1:0] S_DONECHK = 5'd10;
  localparam logic [UPC_W-1:0] S_MODE    = 5'd11;
  localparam logic [UPC_W-1:0] S_SUMINIT = 5'd12;
  localparam logic [UPC_W-1:0] S_SUMRD   = 5'd13;
  localparam logic [UPC_W-1:0] S_SUMADD  = 5'd14;
  localparam logic [UPC_W-1:0] S_SUMEMIT = 5'd15;
  localparam logic [UPC_W-1:0] S_FREE    = 5'd16;
  localparam logic [UPC_W-1:0] S_FLUSH   = 5'd17;

  typedef struct packed {
    isrr_op_e         op;
    logic             ram_rd;
    logic             rd_idx;
    isrr_cond_e       cond;
    logic [UPC_W-1:0] target;
  } isrr_cw_t;

  typedef struct packed {
    isrr_op_e op;
    logic     ram_rd;
    logic     rd_idx;
  } isrr_ctrl_t;

  typedef struct packed {
    logic busy;
    logic head_free;
    logic rel_stop;
    logic rel_nz;
    logic done_lt;
    logic idx_end;
    logic pmode;
    logic stall;
  } isrr_flags_t;

  function automatic isrr_cw_t isrr_ucode(input logic [UPC_W-1:0] pc);
    isrr_cw_t cw;
    cw = '{op: OP_NONE, ram_rd: 1'b0, rd_idx: 1'b0, cond: C_NEXT, target: S_IDLE};
    case (pc)
      S_IDLE: begin
        cw.op = OP_ACCEPT; cw.cond = C_NO_IN; cw.target = S_IDLE;
      end
      S_CHECK: begin
        cw.cond = C_BUSY; cw.target = S_DROP;
      end
      S_UPDATE: begin
        cw.op = OP_UPDATE; cw.cond = C_ALWAYS; cw.target = S_WALK;
      end
      S_DROP: begin
        cw.op = OP_EMIT_DROP; cw.cond = C_ALWAYS; cw.target = S_FLUSH;
      end
      S_WALK: begin
        cw.cond = C_HEAD_FREE; cw.target = S_FLUSH;
      end
      S_WMODE: begin
        cw.cond = C_NOT_PMODE; cw.target = S_DONECHK;
      end
      S_LOOP: begin
        cw.op = OP_RD_REL; cw.ram_rd = 1'b1;
        cw.cond = C_REL_STOP; cw.target = S_DONECHK;
      end
      S_LTEST: begin
        cw.cond = C_REL_NZ; cw.target = S_LSLICE;
      end
      S_LHDR: begin
        cw.op = OP_EMIT_HDR;
      end
      S_LSLICE: begin
        cw.op = OP_EMIT_SLICE; cw.cond = C_ALWAYS; cw.target = S_LOOP;
      end
      S_DONECHK: begin
        cw.cond = C_DONE_LT; cw.target = S_FLUSH;
      end
      S_MODE: begin
        cw.cond = C_PMODE; cw.target = S_FREE;
      end
      S_SUMINIT: begin
        cw.op = OP_SUM_INIT;
      end
      S_SUMRD: begin
        cw.op = OP_RD_IDX; cw.ram_rd = 1'b1; cw.rd_idx = 1'b1;
        cw.cond = C_IDX_END; cw.target = S_SUMEMIT;
      end
      S_SUMADD: begin
        cw.op = OP_SUM_ADD; cw.cond = C_ALWAYS; cw.target = S_SUMRD;
      end
      S_SUMEMIT: begin
        cw.op = OP_EMIT_WHOLE;
      end
      S_FREE: begin
        cw.op = OP_FREE; cw.cond = C_ALWAYS; cw.target = S_WALK;
      end
      S_FLUSH: begin
        cw.op = OP_FLUSH; cw.cond = C_ALWAYS; cw.target = S_IDLE;
      end
      default: begin
        cw.cond = C_ALWAYS; cw.target = S_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/isrr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module isrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/isrr_seq.sv =====
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on isrr_pkg.
`default_nettype none

module isrr_seq (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire isrr_pkg::isrr_flags_t flags_i,
  output isrr_pkg::isrr_ctrl_t      ctrl_o
);

  logic [isrr_pkg::UPC_W-1:0] upc_q, upc_d;
  isrr_pkg::isrr_cw_t         cw;
  logic                       take;

  assign cw = isrr_pkg::isrr_ucode(upc_q);

  always_comb begin
    case (cw.cond)
      isrr_pkg::C_NEXT:      take = 1'b0;
      isrr_pkg::C_ALWAYS:    take = 1'b1;
      isrr_pkg::C_NO_IN:     take = !in_valid_i;
      isrr_pkg::C_BUSY:      take = flags_i.busy;
      isrr_pkg::C_HEAD_FREE: take = flags_i.head_free;
      isrr_pkg::C_NOT_PMODE: take = !flags_i.pmode;
      isrr_pkg::C_PMODE:     take = flags_i.pmode;
      isrr_pkg::C_REL_STOP:  take = flags_i.rel_stop;
      isrr_pkg::C_REL_NZ:    take = flags_i.rel_nz;
      isrr_pkg::C_DONE_LT:   take = flags_i.done_lt;
      isrr_pkg::C_IDX_END:   take = flags_i.idx_end;
      default:               take = 1'b0;
    endcase
  end

  always_comb begin
    upc_d = upc_q;
    if (!flags_i.stall) begin
      upc_d = take ? cw.target : upc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= isrr_pkg::S_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctrl_o.op     = cw.op;
  assign ctrl_o.ram_rd = cw.ram_rd;
  assign ctrl_o.rd_idx = cw.rd_idx;

endmodule

`default_nettype wire

// ===== hw/rtl/isrr_dp.sv =====
// Datapath: config registers, ring slot state, slice size RAM, pending and output words.
// Depends on isrr_pkg and isrr_ram; driven by isrr_seq.
`default_nettype none

module isrr_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire isrr_pkg::isrr_ctrl_t                ctrl_i,
  output isrr_pkg::isrr_flags_t                    flags_o,
  input  wire logic                                in_valid_i,
  input  wire isrr_pkg::isrr_in_t                  in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output isrr_pkg::isrr_out_t                      out_data_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [isrr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [isrr_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int SLOT_W = isrr_pkg::SLOT_W;
  localparam int NS     = isrr_pkg::RING_SLOTS;
  localparam int MS     = isrr_pkg::MAX_SLICES;
  localparam int REL_W  = isrr_pkg::REL_W;
  localparam int CNT_W  = isrr_pkg::CNT_W;
  localparam int SIDX_W = isrr_pkg::SIDX_W;
  localparam int WORD_W = isrr_pkg::WORD_W;

  // config
  logic                          pmode_q;
  logic [isrr_pkg::SPF_W-1:0]    spf_q;
  logic [isrr_pkg::HDR_W-1:0]    hdr_q;

  // slot state
  logic [NS-1:0]                 sv_q;
  logic [isrr_pkg::FRAME_W-1:0]  sf_q   [NS];
  logic [CNT_W-1:0]              sd_q   [NS];
  logic [NS-1:0]                 se_q;
  logic [MS-1:0]                 sr_q   [NS];
  logic [REL_W-1:0]              srel_q [NS];
  logic [WORD_W-1:0]             so_q   [NS];

  logic [SLOT_W-1:0]             sa_q, head_q;
  isrr_pkg::isrr_in_t            ev_q;
  logic [WORD_W-1:0]             acc_q;
  logic [REL_W-1:0]              idx_q;

  isrr_pkg::isrr_out_t           pend_q, out_q, new_res, fwd_res;
  logic                          pend_v_q, out_v_q;

  logic [isrr_pkg::BYTES_W-1:0]  rdata;
  logic [$clog2(isrr_pkg::STORE_DEPTH)-1:0] waddr, raddr;

  logic [REL_W-1:0]              n;
  logic                          cur_valid, cur_err, rel_bit, idx_bit, busy;
  logic [isrr_pkg::FRAME_W-1:0]  cur_frame;
  logic [CNT_W-1:0]              cur_done;
  logic [MS-1:0]                 cur_ready;
  logic [REL_W-1:0]              cur_rel;
  logic [WORD_W-1:0]             cur_off;
  logic                          is_emit, is_flush, out_free, stall, go;

  always_comb begin
    if (spf_q == '0) begin
      n = REL_W'(1);
    end else if (REL_W'(spf_q) > REL_W'(MS)) begin
      n = REL_W'(MS);
    end else begin
      n = REL_W'(spf_q);
    end
  end

  assign cur_valid = sv_q[sa_q];
  assign cur_frame = sf_q[sa_q];
  assign cur_done  = sd_q[sa_q];
  assign cur_err   = se_q[sa_q];
  assign cur_ready = sr_q[sa_q];
  assign cur_rel   = srel_q[sa_q];
  assign cur_off   = so_q[sa_q];
  assign rel_bit   = cur_ready[cur_rel[SIDX_W-1:0]];
  assign idx_bit   = cur_ready[idx_q[SIDX_W-1:0]];
  assign busy      = cur_valid && (cur_frame != ev_q.frame_id);

  assign is_emit  = ctrl_i.op inside {isrr_pkg::OP_EMIT_DROP, isrr_pkg::OP_EMIT_HDR,
                                      isrr_pkg::OP_EMIT_SLICE, isrr_pkg::OP_EMIT_WHOLE};
  assign is_flush = (ctrl_i.op == isrr_pkg::OP_FLUSH);
  assign out_free = !out_v_q || out_ready_i;
  assign stall    = (is_emit || is_flush) && pend_v_q && !out_free;
  assign go       = !stall;

  assign flags_o.busy      = busy;
  assign flags_o.head_free = !cur_valid;
  assign flags_o.rel_stop  = (cur_rel >= n) || !rel_bit;
  assign flags_o.rel_nz    = (cur_rel != '0);
  assign flags_o.done_lt   = (cur_done < CNT_W'(n));
  assign flags_o.idx_end   = (idx_q >= n);
  assign flags_o.pmode     = pmode_q;
  assign flags_o.stall     = stall;

  // slice size store
  assign waddr = {sa_q, ev_q.slice_index};
  assign raddr = {sa_q, ctrl_i.rd_idx ? idx_q[SIDX_W-1:0] : cur_rel[SIDX_W-1:0]};

  isrr_ram #(
    .WIDTH (isrr_pkg::BYTES_W),
    .DEPTH (isrr_pkg::STORE_DEPTH)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.op == isrr_pkg::OP_UPDATE),
    .waddr_i (waddr),
    .wdata_i (ev_q.slice_bytes),
    .re_i    (ctrl_i.ram_rd),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    new_res = '0;
    case (ctrl_i.op)
      isrr_pkg::OP_EMIT_DROP: begin
        new_res.out_frame = ev_q.frame_id;
        new_res.status    = 1'b1;
      end
      isrr_pkg::OP_EMIT_HDR: begin
        new_res.out_frame    = cur_frame;
        new_res.byte_length  = WORD_W'(hdr_q);
        new_res.is_header    = 1'b1;
        new_res.frame_failed = cur_err;
      end
      isrr_pkg::OP_EMIT_SLICE: begin
        new_res.out_frame     = cur_frame;
        new_res.byte_offset   = cur_off;
        new_res.byte_length   = WORD_W'(rdata);
        new_res.last_in_frame = (cur_rel == n - 1'b1);
        new_res.frame_failed  = cur_err;
      end
      isrr_pkg::OP_EMIT_WHOLE: begin
        new_res.out_frame     = cur_frame;
        new_res.byte_length   = acc_q;
        new_res.last_in_frame = 1'b1;
        new_res.frame_failed  = cur_err;
      end
      default: begin
        new_res = '0;
      end
    endcase
  end

  // word moving from pending to output; the flush marks the end of the run
  always_comb begin
    fwd_res             = pend_q;
    fwd_res.last_of_run = is_flush;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pmode_q  <= 1'b0;
      spf_q    <= isrr_pkg::SPF_W'(1);
      hdr_q    <= '0;
      sv_q     <= '0;
      se_q     <= '0;
      sa_q     <= '0;
      head_q   <= '0;
      idx_q    <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      for (int i = 0; i < NS; i++) begin
        sd_q[i]   <= '0;
        sr_q[i]   <= '0;
        srel_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          isrr_pkg::CFG_PMODE: pmode_q <= cfg_data_i[0];
          isrr_pkg::CFG_SPF:   spf_q   <= cfg_data_i[isrr_pkg::SPF_W-1:0];
          isrr_pkg::CFG_HDR:   hdr_q   <= cfg_data_i[isrr_pkg::HDR_W-1:0];
          default: ;
        endcase
      end

      if (go && (is_emit || is_flush) && pend_v_q) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end

      if (go && is_emit) begin
        pend_v_q <= 1'b1;
      end else if (go && is_flush) begin
        pend_v_q <= 1'b0;
      end

      case (ctrl_i.op)
        isrr_pkg::OP_ACCEPT: begin
          if (in_valid_i) begin
            sa_q <= in_data_i.frame_id[SLOT_W-1:0];
          end
        end
        isrr_pkg::OP_UPDATE: begin
          sv_q[sa_q] <= 1'b1;
          if (!cur_valid) begin
            sd_q[sa_q]   <= CNT_W'(1);
            srel_q[sa_q] <= '0;
          end else if (cur_done != isrr_pkg::DONE_SAT) begin
            sd_q[sa_q] <= cur_done + 1'b1;
          end
          se_q[sa_q] <= (cur_valid && cur_err) || ev_q.slice_failed;
          sr_q[sa_q] <= (cur_valid ? cur_ready : '0) | (MS'(1) << ev_q.slice_index);
          sa_q       <= head_q;
        end
        isrr_pkg::OP_EMIT_SLICE: begin
          if (go) begin
            srel_q[sa_q] <= cur_rel + 1'b1;
          end
        end
        isrr_pkg::OP_SUM_INIT: begin
          idx_q <= '0;
        end
        isrr_pkg::OP_SUM_ADD: begin
          idx_q <= idx_q + 1'b1;
        end
        isrr_pkg::OP_FREE: begin
          sv_q[sa_q] <= 1'b0;
          head_q     <= head_q + 1'b1;
          sa_q       <= head_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (go && (is_emit || is_flush) && pend_v_q) begin
      out_q <= fwd_res;
    end
    if (go && is_emit) begin
      pend_q <= new_res;
    end
    case (ctrl_i.op)
      isrr_pkg::OP_ACCEPT: begin
        if (in_valid_i) begin
          ev_q <= in_data_i;
        end
      end
      isrr_pkg::OP_UPDATE: begin
        sf_q[sa_q] <= ev_q.frame_id;
        if (!cur_valid) begin
          so_q[sa_q] <= '0;
        end
      end
      isrr_pkg::OP_EMIT_HDR: begin
        if (go) begin
          so_q[sa_q] <= WORD_W'(hdr_q);
        end
      end
      isrr_pkg::OP_EMIT_SLICE: begin
        if (go) begin
          so_q[sa_q] <= cur_off + WORD_W'(rdata);
        end
      end
      isrr_pkg::OP_SUM_INIT: begin
        acc_q <= WORD_W'(hdr_q);
      end
      isrr_pkg::OP_SUM_ADD: begin
        if (idx_bit) begin
          acc_q <= acc_q + WORD_W'(rdata);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_flush_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_flush && go) |=> !pend_v_q)
    else $error("pending word survived flush");

  a_accept_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == isrr_pkg::OP_ACCEPT) |-> !pend_v_q)
    else $error("pending word left over at accept");

  a_update_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == isrr_pkg::OP_UPDATE) |-> !busy)
    else $error("update into slot owned by another frame");

  a_slice_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == isrr_pkg::OP_EMIT_SLICE) |-> ((cur_rel < n) && rel_bit))
    else $error("slice released before it is ready");

  a_head_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == isrr_pkg::OP_FREE) |=> (head_q == SLOT_W'($past(head_q) + 1'b1)))
    else $error("head did not advance on free");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/inorder_slice_release_reorder.sv =====
// Top level of the in-order slice release buffer: sequencer plus datapath.
// Depends on isrr_pkg, isrr_seq, isrr_dp (and isrr_ram through isrr_dp).
//
// Slice-completion events enter on the in channel and are handled one at a time by a
// microcoded sequencer; the next event is taken once every word caused by the current one
// has been handed to the output register. A dropped event (slot held by another frame)
// is accepted, checked, answered with a drop word and flushed. An accepted slice updates
// its slot, then the ring walk looks at each occupied head slot: in packetization mode it
// releases the ready slice words in order (the first with the header word), and it retires
// each complete frame; in whole-frame mode a retired frame first sums its slice sizes,
// walking the slice RAM. Output back-pressure stalls the emit and flush steps. The last
// word of each event carries last_of_run. No clearing pass is needed after reset.
`default_nettype none

module inorder_slice_release_reorder (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire isrr_pkg::isrr_in_t               in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output isrr_pkg::isrr_out_t                   out_data_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [isrr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [isrr_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  isrr_pkg::isrr_ctrl_t  ctrl;
  isrr_pkg::isrr_flags_t flags;

  isrr_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .flags_i    (flags),
    .ctrl_o     (ctrl)
  );

  isrr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .flags_o     (flags),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  assign in_ready_o = (ctrl.op == isrr_pkg::OP_ACCEPT);

endmodule

`default_nettype wire

// ===== sim/tb_inorder_slice_release_reorder.sv =====
// Self-checking bench for inorder_slice_release_reorder: directed and random slice events,
// predicted packet release compared word by word. Needs isrr_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_inorder_slice_release_reorder;

  localparam int ITEMS_TARGET  = 210;
  localparam int SETTLE_CYCLES = 120;
  localparam int STALL_LIMIT   = 2000;
  localparam int LONG_HOLD     = 300;
  localparam int NSLOT         = isrr_pkg::RING_SLOTS;
  localparam int MSL           = isrr_pkg::MAX_SLICES;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  isrr_pkg::isrr_in_t              in_data;
  logic                            out_valid;
  logic                            out_ready;
  isrr_pkg::isrr_out_t             out_data;
  logic                            cfg_we;
  logic [isrr_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [isrr_pkg::CFG_DATA_W-1:0] cfg_data;

  // shadow registers
  logic        mode_pk;
  logic [3:0]  spf_cfg;
  logic [15:0] hdr_len;

  // ring state as the block should hold it
  logic           slot_busy [NSLOT];
  logic [31:0]    slot_fid  [NSLOT];
  logic [3:0]     slot_cnt  [NSLOT];
  logic           slot_err  [NSLOT];
  logic [MSL-1:0] slot_rdy  [NSLOT];
  int             slot_rel  [NSLOT];
  logic [31:0]    slot_off  [NSLOT];
  logic [23:0]    size_mem  [isrr_pkg::STORE_DEPTH];
  int             head_slot;

  isrr_pkg::isrr_out_t packets_due[$];
  isrr_pkg::isrr_out_t want_pkt;

  int  events_sent    = 0;
  int  packets_seen   = 0;
  int  frames_retired = 0;
  int  events_dropped = 0;
  int  mismatches     = 0;
  int  quiet_cycles   = 0;
  int  hold_request   = 0;
  bit  calm           = 1'b0;

  inorder_slice_release_reorder DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int eff_slices();
    if (spf_cfg == 4'd0) return 1;
    if (spf_cfg > MSL) return MSL;
    return int'(spf_cfg);
  endfunction

  function automatic isrr_pkg::isrr_out_t pkt(input logic [31:0] f, input logic [31:0] off,
                                              input logic [31:0] len, input logic hdr,
                                              input logic last, input logic fail,
                                              input logic stat);
    isrr_pkg::isrr_out_t p;
    p.out_frame     = f;
    p.byte_offset   = off;
    p.byte_length   = len;
    p.is_header     = hdr;
    p.last_in_frame = last;
    p.frame_failed  = fail;
    p.status        = stat;
    p.last_of_run   = 1'b0;
    return p;
  endfunction

  function automatic isrr_pkg::isrr_in_t slice_evt(input logic [31:0] fid,
                                                   input logic [2:0] sidx,
                                                   input logic fail,
                                                   input logic [23:0] nbytes);
    isrr_pkg::isrr_in_t w;
    w.frame_id     = fid;
    w.slice_index  = sidx;
    w.slice_failed = fail;
    w.slice_bytes  = nbytes;
    return w;
  endfunction

  function automatic isrr_pkg::isrr_in_t rand_event(input logic [31:0] fid, input int sidx);
    int          r;
    logic [31:0] b;
    r = $urandom_range(99);
    b = $urandom();
    if (r < 10) b = '0;
    else if (r < 20) b = '1;
    return slice_evt(fid, sidx[2:0], $urandom_range(99) < 15, b[23:0]);
  endfunction

  // Updates the ring and queues every packet this slice event releases.
  task automatic retire_slice(input isrr_pkg::isrr_in_t w);
    isrr_pkg::isrr_out_t run[$];
    int                  n, s, h, r;
    logic [31:0]         total;
    begin
      n = eff_slices();
      s = int'(w.frame_id[isrr_pkg::SLOT_W-1:0]);
      if (slot_busy[s] && slot_fid[s] != w.frame_id) begin
        run.push_back(pkt(w.frame_id, 0, 0, 0, 0, 0, 1));
        events_dropped++;
      end else begin
        if (!slot_busy[s]) begin
          slot_busy[s] = 1'b1;
          slot_fid[s]  = w.frame_id;
          slot_cnt[s]  = '0;
          slot_err[s]  = 1'b0;
          slot_rdy[s]  = '0;
          slot_rel[s]  = 0;
          slot_off[s]  = '0;
        end
        if (slot_cnt[s] != 4'hF) slot_cnt[s] = slot_cnt[s] + 4'd1;
        slot_err[s] = slot_err[s] | w.slice_failed;
        slot_rdy[s][w.slice_index] = 1'b1;
        size_mem[s * MSL + int'(w.slice_index)] = w.slice_bytes;
        for (int walk = 0; walk < NSLOT; walk++) begin
          h = head_slot;
          if (!slot_busy[h]) break;
          if (mode_pk) begin
            while (slot_rel[h] < n && slot_rdy[h][slot_rel[h]]) begin
              r = slot_rel[h];
              if (r == 0) begin
                run.push_back(pkt(slot_fid[h], 0, {16'd0, hdr_len}, 1, 0, slot_err[h], 0));
                slot_off[h] = {16'd0, hdr_len};
              end
              run.push_back(pkt(slot_fid[h], slot_off[h], {8'd0, size_mem[h * MSL + r]},
                                0, r == n - 1, slot_err[h], 0));
              slot_off[h] = slot_off[h] + {8'd0, size_mem[h * MSL + r]};
              slot_rel[h] = r + 1;
            end
          end
          if (int'(slot_cnt[h]) < n) break;
          if (!mode_pk) begin
            total = {16'd0, hdr_len};
            for (int i = 0; i < n; i++)
              if (slot_rdy[h][i]) total = total + {8'd0, size_mem[h * MSL + i]};
            run.push_back(pkt(slot_fid[h], 0, total, 0, 1, slot_err[h], 0));
          end
          slot_busy[h] = 1'b0;
          head_slot = (h + 1) % NSLOT;
          frames_retired++;
        end
      end
      if (run.size() > 0) begin
        run[run.size() - 1].last_of_run = 1'b1;
        foreach (run[i]) packets_due.push_back(run[i]);
      end
    end
  endtask

  // Called at a falling edge; returns at a falling edge.
  task automatic send_event(input isrr_pkg::isrr_in_t w);
    begin
      if (!calm && $urandom_range(99) < 8) repeat ($urandom_range(1, 20)) @(negedge clk);
      in_data  = w;
      in_valid = 1'b1;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      retire_slice(w);
      events_sent++;
      @(negedge clk);
      in_valid = 1'b0;
    end
  endtask

  task automatic write_reg(input logic [isrr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [isrr_pkg::CFG_DATA_W-1:0] val);
    begin
      cfg_we   = 1'b1;
      cfg_idx  = idx;
      cfg_data = val;
      case (idx)
        isrr_pkg::CFG_PMODE: mode_pk = val[0];
        isrr_pkg::CFG_SPF:   spf_cfg = val[3:0];
        isrr_pkg::CFG_HDR:   hdr_len = val;
        default: ;
      endcase
      @(negedge clk);
      cfg_we = 1'b0;
    end
  endtask

  task automatic settle();
    begin
      while (packets_due.size() != 0) @(negedge clk);
      repeat (SETTLE_CYCLES) @(negedge clk);
    end
  endtask

  task automatic set_config(input logic pm, input logic [3:0] spf, input logic [15:0] hdr);
    logic [31:0] rnd;
    begin
      rnd = $urandom();
      write_reg(isrr_pkg::CFG_PMODE, {rnd[15:1], pm});
      write_reg(isrr_pkg::CFG_SPF, {rnd[31:20], spf});
      write_reg(isrr_pkg::CFG_HDR, hdr);
    end
  endtask

  // Sends the missing slices of every occupied slot so the ring can retire.
  task automatic close_open_frames();
    logic [31:0] fid;
    int          n;
    begin
      n = eff_slices();
      for (int s = 0; s < NSLOT; s++) begin
        fid = slot_fid[s];
        for (int i = 0; i < n; i++)
          if (slot_busy[s] && slot_fid[s] == fid && !slot_rdy[s][i])
            send_event(rand_event(fid, i));
      end
    end
  endtask

  // Consecutive frames from the head slot, slices shuffled, with some noise mixed in.
  task automatic send_window(input int frames);
    isrr_pkg::isrr_in_t evs[$];
    isrr_pkg::isrr_in_t tmp;
    logic [31:0]        base;
    int                 n, j, r;
    begin
      n = eff_slices();
      base = ($urandom() & 32'hFFFF_FFFC) | head_slot;
      for (int f = 0; f < frames; f++)
        for (int i = 0; i < n; i++) evs.push_back(rand_event(base + f, i));
      for (int i = evs.size() - 1; i > 0; i--) begin
        j = $urandom_range(i);
        tmp = evs[i];
        evs[i] = evs[j];
        evs[j] = tmp;
      end
      foreach (evs[i]) begin
        send_event(evs[i]);
        r = $urandom_range(99);
        if (r < 5)
          send_event(rand_event(evs[i].frame_id, evs[i].slice_index));
        else if (r < 10)
          send_event(rand_event(evs[i].frame_id + ($urandom_range(1, 1023) << 2),
                                $urandom_range(7)));
        else if (r < 12)
          send_event(rand_event($urandom(), $urandom_range(7)));
      end
      close_open_frames();
    end
  endtask

  task automatic test_reset_defaults();
    begin
      send_event(slice_evt(32'd0, 3'd0, 1'b1, 24'hFF_FFFF));
      settle();
    end
  endtask

  task automatic test_whole_frame();
    begin
      set_config(1'b0, 4'd4, 16'hFFFF);
      send_event(slice_evt(32'd5, 3'd3, 1'b0, 24'd0));
      send_event(slice_evt(32'd9, 3'd0, 1'b0, 24'd123));   // slot busy
      send_event(slice_evt(32'd5, 3'd1, 1'b1, 24'hFF_FFFF));
      send_event(slice_evt(32'd5, 3'd0, 1'b0, 24'd1));
      send_event(slice_evt(32'd5, 3'd2, 1'b0, 24'd7));
      settle();
    end
  endtask

  task automatic test_duplicate_slice();
    begin
      repeat (3) send_event(slice_evt(32'd6, 3'd2, 1'b0, 24'd10));
      send_event(slice_evt(32'd6, 3'd2, 1'b0, 24'd20));
      settle();
    end
  endtask

  task automatic test_packet_order();
    begin
      set_config(1'b1, 4'd15, 16'd0);
      for (int i = 1; i < MSL; i++)
        send_event(slice_evt(32'hFFFF_FFFF, i[2:0], i == 3,
                             i == 7 ? 24'd0 : 24'($urandom())));
      send_event(slice_evt(32'hFFFF_FFFF, 3'd0, 1'b0, 24'h00_0100));
      settle();
    end
  endtask

  task automatic test_short_frames();
    begin
      set_config(1'b1, 4'd0, 16'd100);
      send_event(slice_evt(32'd4, 3'd0, 1'b0, 24'd50));
      send_event(slice_evt(32'd5, 3'd5, 1'b1, 24'd77));   // index past slice count
      settle();
    end
  endtask

  task automatic test_multi_retire();
    begin
      set_config(1'b0, 4'd2, 16'd100);
      send_event(slice_evt(32'd3, 3'd1, 1'b0, 24'd11));
      send_event(slice_evt(32'd3, 3'd0, 1'b1, 24'd12));
      send_event(slice_evt(32'd2, 3'd0, 1'b0, 24'd13));
      send_event(slice_evt(32'd2, 3'd1, 1'b0, 24'd14));
      settle();
    end
  endtask

  // Head frame completes last, so its final slice releases the whole ring at once.
  task automatic test_longest_run();
    logic [31:0] base;
    begin
      set_config(1'b1, 4'd8, 16'($urandom()));
      calm = 1'b1;
      base = ($urandom() & 32'hFFFF_FFFC) | head_slot;
      for (int i = 0; i < MSL; i++)
        for (int f = 1; f < NSLOT; f++) send_event(rand_event(base + f, MSL - 1 - i));
      for (int i = MSL - 1; i >= 0; i--) send_event(rand_event(base, i));
      calm = 1'b0;
      settle();
    end
  endtask

  task automatic test_output_hold();
    begin
      set_config(1'b1, 4'd8, 16'($urandom()));
      hold_request = LONG_HOLD;
      send_window(NSLOT);
      settle();
    end
  endtask

  task automatic test_random_mix();
    int          r;
    logic [3:0]  spf;
    logic [15:0] hdr;
    begin
      while (events_sent < ITEMS_TARGET) begin
        r = $urandom_range(9);
        spf = (r == 0) ? 4'd0 : (r == 1) ? 4'd15 : (r == 2) ? 4'd1 : (r == 3) ? 4'd8 :
              4'($urandom_range(1, MSL));
        r = $urandom_range(9);
        hdr = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom());
        set_config(1'($urandom_range(1)), spf, hdr);
        close_open_frames();
        repeat ($urandom_range(1, 3))
          if (events_sent < ITEMS_TARGET) send_window($urandom_range(1, NSLOT));
        settle();
      end
    end
  endtask

  // receiver: random back-pressure, plus long holds on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        out_ready = 1'b0;
        for (int c = 0; c < hold_request; c++) @(negedge clk);
        hold_request = 0;
      end
      out_ready = calm || ($urandom_range(99) >= 8);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    begin
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      packets_seen++;
      if (packets_due.size() == 0) begin
        $error("unexpected word: frame %0h offset %0h length %0h", out_data.out_frame,
               out_data.byte_offset, out_data.byte_length);
        mismatches++;
      end else begin
        want_pkt = packets_due.pop_front();
        check_field("out_frame", want_pkt.out_frame, out_data.out_frame);
        check_field("byte_offset", want_pkt.byte_offset, out_data.byte_offset);
        check_field("byte_length", want_pkt.byte_length, out_data.byte_length);
        check_field("is_header", want_pkt.is_header, out_data.is_header);
        check_field("last_in_frame", want_pkt.last_in_frame, out_data.last_in_frame);
        check_field("frame_failed", want_pkt.frame_failed, out_data.frame_failed);
        check_field("status", want_pkt.status, out_data.status);
        check_field("last_of_run", want_pkt.last_of_run, out_data.last_of_run);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d words still due",
               STALL_LIMIT, packets_due.size());
      $display("tb_inorder_slice_release_reorder: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    cfg_we   = 1'b0;
    cfg_idx  = isrr_pkg::CFG_PMODE;
    cfg_data = '0;
    mode_pk  = 1'b0;
    spf_cfg  = 4'd1;
    hdr_len  = '0;
    head_slot = 0;
    for (int s = 0; s < NSLOT; s++) begin
      slot_busy[s] = 1'b0;
      slot_fid[s]  = '0;
      slot_cnt[s]  = '0;
      slot_err[s]  = 1'b0;
      slot_rdy[s]  = '0;
      slot_rel[s]  = 0;
      slot_off[s]  = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_whole_frame();
    test_duplicate_slice();
    test_packet_order();
    test_short_frames();
    test_multi_retire();
    test_longest_run();
    test_output_hold();
    test_random_mix();
    close_open_frames();
    settle();

    $display("%0d slice events, %0d words checked, %0d frames retired, %0d events dropped",
             events_sent, packets_seen, frames_retired, events_dropped);
    $display("both release modes, slice counts 0..15, headers 0..65535, long output holds");
    if (mismatches == 0 && packets_due.size() == 0)
      $display("tb_inorder_slice_release_reorder: clean");
    else
      $display("tb_inorder_slice_release_reorder: errors");
    $finish;
  end

endmodule
